// ----- hdl/obbov_pkg.sv -----
`default_nettype none

package obbov_pkg;

  // Quarter-wave sine table has SINE_TABLE_DEPTH+1 entries.
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1);

  localparam int COORD_W  = 24;
  localparam int EXT_W    = 23;
  localparam int ANG_W    = 16;
  localparam int MARGIN_W = 16;
  localparam int TRIG_W   = 16;
  localparam int MAG_W    = 15;
  localparam int QUARTER  = 16384;

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint C1      = 64'sd1686629714;
  localparam longint C3      = 64'sd693598668;
  localparam longint C5      = 64'sd85569306;
  localparam longint C7      = 64'sd5026995;
  localparam longint C9      = 64'sd172273;

  typedef logic [MAG_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cz;
    logic        [EXT_W-1:0]   hl;
    logic        [EXT_W-1:0]   hw;
    logic signed [COORD_W-1:0] mnx;
    logic signed [COORD_W-1:0] mnz;
    logic signed [COORD_W-1:0] mxx;
    logic signed [COORD_W-1:0] mxz;
  } geo_t;

  typedef struct packed {
    geo_t             g;
    logic [ANG_W-1:0] ang;
  } item_t;

  typedef struct packed {
    geo_t                     g;
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
    logic        [MAG_W-1:0]  sm;
    logic        [MAG_W-1:0]  cm;
  } trig_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cz;
    logic signed [COORD_W-1:0] bminx;
    logic signed [COORD_W-1:0] bmaxx;
    logic signed [COORD_W-1:0] bminz;
    logic signed [COORD_W-1:0] bmaxz;
    logic        [EXT_W-1:0]   hl;
    logic        [EXT_W-1:0]   hw;
    logic        [30:0]        n;
    logic        [38:0]        r0;
    logic        [38:0]        r1;
    logic signed [40:0]        p2;
    logic signed [40:0]        p3;
    logic signed [40:0]        bmin2;
    logic signed [40:0]        bmax2;
    logic signed [40:0]        bmin3;
    logic signed [40:0]        bmax3;
  } proj_t;

  // Odd polynomial to x^9 in Q30, rounded to Q15 and clamped.
  function automatic logic [MAG_W-1:0] quarter_entry(input int i);
    longint ii, x, x2, t, s, e;
    ii = longint'(i);
    if (ii > SINE_TABLE_DEPTH) begin
      ii = SINE_TABLE_DEPTH;
    end
    x  = (ii <<< 30) / SINE_TABLE_DEPTH;
    x2 = (x * x) / ONE_Q30;
    t  = C9;
    t  = C7 - (x2 * t) / ONE_Q30;
    t  = C5 - (x2 * t) / ONE_Q30;
    t  = C3 - (x2 * t) / ONE_Q30;
    t  = C1 - (x2 * t) / ONE_Q30;
    s  = (x * t) / ONE_Q30;
    e  = (s + 64'sd16384) / 64'sd32768;
    if (e > 64'sd32767) begin
      e = 64'sd32767;
    end
    if (e < 64'sd0) begin
      e = 64'sd0;
    end
    return MAG_W'(e);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      rom[i] = quarter_entry(i);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/obbov_trig.sv -----
`default_nettype none

module obbov_trig (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire obbov_pkg::item_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output obbov_pkg::trig_t      out_data
);
  import obbov_pkg::*;

  localparam int PW = MAG_W + IDX_W;
  localparam sine_rom_t SINE_ROM = build_sine_rom();

  typedef struct packed {
    geo_t             g;
    logic [IDX_W-1:0] sidx;
    logic [IDX_W-1:0] cidx;
    logic             sneg;
    logic             cneg;
  } lut_t;

  logic       v1_r, v2_r;
  logic       rdy1, rdy2;
  lut_t       s1_r, s1_nxt;
  trig_t      s2_r, s2_nxt;

  logic [1:0]       quad;
  logic [13:0]      phase;
  logic [MAG_W-1:0] u_sin, u_cos;
  logic [PW-1:0]    prod_sin, prod_cos;
  logic [MAG_W-1:0] sin_mag, cos_mag;
  logic signed [TRIG_W-1:0] sin_pos, cos_pos;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Fold the angle into the first quadrant; cosine is sine a quarter turn on.
  always_comb begin
    quad     = in_data.ang[15:14];
    phase    = in_data.ang[13:0];
    u_sin    = quad[0] ? MAG_W'(QUARTER) - {1'b0, phase} : {1'b0, phase};
    u_cos    = quad[0] ? {1'b0, phase} : MAG_W'(QUARTER) - {1'b0, phase};
    prod_sin = PW'(u_sin) * PW'(SINE_TABLE_DEPTH);
    prod_cos = PW'(u_cos) * PW'(SINE_TABLE_DEPTH);
    s1_nxt.g    = in_data.g;
    s1_nxt.sidx = prod_sin[IDX_W+13:14];
    s1_nxt.cidx = prod_cos[IDX_W+13:14];
    s1_nxt.sneg = quad[1];
    s1_nxt.cneg = quad[1] ^ quad[0];
  end

  always_comb begin
    sin_mag   = SINE_ROM[s1_r.sidx];
    cos_mag   = SINE_ROM[s1_r.cidx];
    sin_pos   = $signed({1'b0, sin_mag});
    cos_pos   = $signed({1'b0, cos_mag});
    s2_nxt.g  = s1_r.g;
    s2_nxt.s  = s1_r.sneg ? -sin_pos : sin_pos;
    s2_nxt.c  = s1_r.cneg ? -cos_pos : cos_pos;
    s2_nxt.sm = sin_mag;
    s2_nxt.cm = cos_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (rdy2 && v1_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = s2_r;

endmodule

`default_nettype wire

// ----- hdl/obbov_proj.sv -----
`default_nettype none

module obbov_proj (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire obbov_pkg::trig_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output obbov_pkg::proj_t      out_data
);
  import obbov_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cz;
    logic signed [COORD_W-1:0] bminx;
    logic signed [COORD_W-1:0] bmaxx;
    logic signed [COORD_W-1:0] bminz;
    logic signed [COORD_W-1:0] bmaxz;
    logic        [EXT_W-1:0]   hl;
    logic        [EXT_W-1:0]   hw;
    logic        [29:0]        cc;
    logic        [29:0]        ss;
    logic        [37:0]        ch;
    logic        [37:0]        sw;
    logic        [37:0]        sl;
    logic        [37:0]        cw;
    logic signed [39:0]        pxc;
    logic signed [39:0]        pzs;
    logic signed [39:0]        pxs;
    logic signed [39:0]        pzc;
    logic signed [39:0]        bxc_mn;
    logic signed [39:0]        bxc_mx;
    logic signed [39:0]        bzs_mn;
    logic signed [39:0]        bzs_mx;
    logic signed [39:0]        bxs_mn;
    logic signed [39:0]        bxs_mx;
    logic signed [39:0]        bzc_mn;
    logic signed [39:0]        bzc_mx;
  } mul_t;

  logic  v3_r, v4_r;
  logic  rdy3, rdy4;
  mul_t  s3_r, s3_nxt;
  proj_t s4_r, s4_nxt;

  logic signed [39:0] lo_xc, hi_xc, lo_zs, hi_zs, lo_xs, hi_xs, lo_zc, hi_zc;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign in_ready = rdy3;

  // Every product that the four axes need, one multiplier each.
  always_comb begin
    s3_nxt.cx     = in_data.g.cx;
    s3_nxt.cz     = in_data.g.cz;
    s3_nxt.bminx  = (in_data.g.mnx < in_data.g.mxx) ? in_data.g.mnx : in_data.g.mxx;
    s3_nxt.bmaxx  = (in_data.g.mnx < in_data.g.mxx) ? in_data.g.mxx : in_data.g.mnx;
    s3_nxt.bminz  = (in_data.g.mnz < in_data.g.mxz) ? in_data.g.mnz : in_data.g.mxz;
    s3_nxt.bmaxz  = (in_data.g.mnz < in_data.g.mxz) ? in_data.g.mxz : in_data.g.mnz;
    s3_nxt.hl     = in_data.g.hl;
    s3_nxt.hw     = in_data.g.hw;
    s3_nxt.cc     = 30'(in_data.cm) * 30'(in_data.cm);
    s3_nxt.ss     = 30'(in_data.sm) * 30'(in_data.sm);
    s3_nxt.ch     = 38'(in_data.cm) * 38'(in_data.g.hl);
    s3_nxt.sw     = 38'(in_data.sm) * 38'(in_data.g.hw);
    s3_nxt.sl     = 38'(in_data.sm) * 38'(in_data.g.hl);
    s3_nxt.cw     = 38'(in_data.cm) * 38'(in_data.g.hw);
    s3_nxt.pxc    = 40'(in_data.g.cx) * 40'(in_data.c);
    s3_nxt.pzs    = 40'(in_data.g.cz) * 40'(in_data.s);
    s3_nxt.pxs    = 40'(in_data.g.cx) * 40'(in_data.s);
    s3_nxt.pzc    = 40'(in_data.g.cz) * 40'(in_data.c);
    s3_nxt.bxc_mn = 40'(in_data.g.mnx) * 40'(in_data.c);
    s3_nxt.bxc_mx = 40'(in_data.g.mxx) * 40'(in_data.c);
    s3_nxt.bzs_mn = 40'(in_data.g.mnz) * 40'(in_data.s);
    s3_nxt.bzs_mx = 40'(in_data.g.mxz) * 40'(in_data.s);
    s3_nxt.bxs_mn = 40'(in_data.g.mnx) * 40'(in_data.s);
    s3_nxt.bxs_mx = 40'(in_data.g.mxx) * 40'(in_data.s);
    s3_nxt.bzc_mn = 40'(in_data.g.mnz) * 40'(in_data.c);
    s3_nxt.bzc_mx = 40'(in_data.g.mxz) * 40'(in_data.c);
  end

  // The forward axis has z component -sin, so its box term flips min and max.
  always_comb begin
    lo_xc = (s3_r.bxc_mn < s3_r.bxc_mx) ? s3_r.bxc_mn : s3_r.bxc_mx;
    hi_xc = (s3_r.bxc_mn < s3_r.bxc_mx) ? s3_r.bxc_mx : s3_r.bxc_mn;
    lo_zs = (s3_r.bzs_mn < s3_r.bzs_mx) ? s3_r.bzs_mn : s3_r.bzs_mx;
    hi_zs = (s3_r.bzs_mn < s3_r.bzs_mx) ? s3_r.bzs_mx : s3_r.bzs_mn;
    lo_xs = (s3_r.bxs_mn < s3_r.bxs_mx) ? s3_r.bxs_mn : s3_r.bxs_mx;
    hi_xs = (s3_r.bxs_mn < s3_r.bxs_mx) ? s3_r.bxs_mx : s3_r.bxs_mn;
    lo_zc = (s3_r.bzc_mn < s3_r.bzc_mx) ? s3_r.bzc_mn : s3_r.bzc_mx;
    hi_zc = (s3_r.bzc_mn < s3_r.bzc_mx) ? s3_r.bzc_mx : s3_r.bzc_mn;
    s4_nxt.cx    = s3_r.cx;
    s4_nxt.cz    = s3_r.cz;
    s4_nxt.bminx = s3_r.bminx;
    s4_nxt.bmaxx = s3_r.bmaxx;
    s4_nxt.bminz = s3_r.bminz;
    s4_nxt.bmaxz = s3_r.bmaxz;
    s4_nxt.hl    = s3_r.hl;
    s4_nxt.hw    = s3_r.hw;
    s4_nxt.n     = 31'(s3_r.cc) + 31'(s3_r.ss);
    s4_nxt.r0    = 39'(s3_r.ch) + 39'(s3_r.sw);
    s4_nxt.r1    = 39'(s3_r.sl) + 39'(s3_r.cw);
    s4_nxt.p2    = 41'(s3_r.pxc) - 41'(s3_r.pzs);
    s4_nxt.p3    = 41'(s3_r.pxs) + 41'(s3_r.pzc);
    s4_nxt.bmin2 = 41'(lo_xc) - 41'(hi_zs);
    s4_nxt.bmax2 = 41'(hi_xc) - 41'(lo_zs);
    s4_nxt.bmin3 = 41'(lo_xs) + 41'(lo_zc);
    s4_nxt.bmax3 = 41'(hi_xs) + 41'(hi_zc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy3) begin
        v3_r <= in_valid;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) begin
      s3_r <= s3_nxt;
    end
    if (rdy4 && v3_r) begin
      s4_r <= s4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = s4_r;

endmodule

`default_nettype wire

// ----- hdl/obbov_sep.sv -----
`default_nettype none

module obbov_sep (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [obbov_pkg::MARGIN_W-1:0]  margin,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire obbov_pkg::proj_t                in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_overlap
);
  import obbov_pkg::*;

  typedef struct packed {
    logic               sep01;
    logic signed [40:0] p2;
    logic signed [40:0] p3;
    logic        [53:0] r2;
    logic        [53:0] r3;
    logic signed [40:0] bmin2;
    logic signed [40:0] bmax2;
    logic signed [40:0] bmin3;
    logic signed [40:0] bmax3;
  } fin_t;

  logic v5_r, ov_r;
  logic rdy5, rdy6;
  fin_t s5_r, s5_nxt;
  logic overlap_r, overlap_nxt;

  // Axes x and z are compared with coordinates and margin scaled up by 2^15.
  logic signed [41:0] cx_sh, cz_sh, r0_e, r1_e, m15;
  logic signed [41:0] bminx_sh, bmaxx_sh, bminz_sh, bmaxz_sh;
  logic               sep0, sep1;

  // Rotated axes are compared exactly in Q38.
  logic signed [57:0] p2_sh, p3_sh, r2_e, r3_e, m30;
  logic signed [57:0] bmin2_sh, bmax2_sh, bmin3_sh, bmax3_sh;
  logic               sep2, sep3;

  assign rdy6     = !ov_r || out_ready;
  assign rdy5     = !v5_r || rdy6;
  assign in_ready = rdy5;

  always_comb begin
    cx_sh    = {{3{in_data.cx[23]}}, in_data.cx, 15'b0};
    cz_sh    = {{3{in_data.cz[23]}}, in_data.cz, 15'b0};
    bminx_sh = {{3{in_data.bminx[23]}}, in_data.bminx, 15'b0};
    bmaxx_sh = {{3{in_data.bmaxx[23]}}, in_data.bmaxx, 15'b0};
    bminz_sh = {{3{in_data.bminz[23]}}, in_data.bminz, 15'b0};
    bmaxz_sh = {{3{in_data.bmaxz[23]}}, in_data.bmaxz, 15'b0};
    r0_e     = $signed({3'b0, in_data.r0});
    r1_e     = $signed({3'b0, in_data.r1});
    m15      = $signed({11'b0, margin, 15'b0});
    sep0 = (cx_sh + r0_e + m15 < bminx_sh) || (bmaxx_sh + m15 < cx_sh - r0_e);
    sep1 = (cz_sh + r1_e + m15 < bminz_sh) || (bmaxz_sh + m15 < cz_sh - r1_e);
    s5_nxt.sep01 = sep0 || sep1;
    s5_nxt.p2    = in_data.p2;
    s5_nxt.p3    = in_data.p3;
    s5_nxt.r2    = 54'(in_data.n) * 54'(in_data.hl);
    s5_nxt.r3    = 54'(in_data.n) * 54'(in_data.hw);
    s5_nxt.bmin2 = in_data.bmin2;
    s5_nxt.bmax2 = in_data.bmax2;
    s5_nxt.bmin3 = in_data.bmin3;
    s5_nxt.bmax3 = in_data.bmax3;
  end

  always_comb begin
    p2_sh    = {{2{s5_r.p2[40]}}, s5_r.p2, 15'b0};
    p3_sh    = {{2{s5_r.p3[40]}}, s5_r.p3, 15'b0};
    bmin2_sh = {{2{s5_r.bmin2[40]}}, s5_r.bmin2, 15'b0};
    bmax2_sh = {{2{s5_r.bmax2[40]}}, s5_r.bmax2, 15'b0};
    bmin3_sh = {{2{s5_r.bmin3[40]}}, s5_r.bmin3, 15'b0};
    bmax3_sh = {{2{s5_r.bmax3[40]}}, s5_r.bmax3, 15'b0};
    r2_e     = $signed({4'b0, s5_r.r2});
    r3_e     = $signed({4'b0, s5_r.r3});
    m30      = $signed({12'b0, margin, 30'b0});
    sep2 = (p2_sh + r2_e + m30 < bmin2_sh) || (bmax2_sh + m30 < p2_sh - r2_e);
    sep3 = (p3_sh + r3_e + m30 < bmin3_sh) || (bmax3_sh + m30 < p3_sh - r3_e);
    overlap_nxt = !(s5_r.sep01 || sep2 || sep3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy5) begin
        v5_r <= in_valid;
      end
      if (rdy6) begin
        ov_r <= v5_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && in_valid) begin
      s5_r <= s5_nxt;
    end
    if (rdy6 && v5_r) begin
      overlap_r <= overlap_nxt;
    end
  end

  assign out_valid   = ov_r;
  assign out_overlap = overlap_r;

endmodule

`default_nettype wire

// ----- hdl/obb_aabb_overlap_2d.sv -----
// Separating-axis overlap test of one oriented 2D box against one
// axis-aligned 2D box, tested on the x, z, forward and right axes.
// Input channel (in_valid/in_ready): one box pair per word. Output channel
// (out_valid/out_ready): one word per pair, out_overlap = 1 when no axis
// separates the boxes. Results leave in the order the pairs came in.
// There are six register stages: angle fold and table index, sine table
// read, product stage, sum stage, radius multiply with the x/z compares,
// and the rotated-axis compare into the output register. A pair moves
// through them in that order, and out_valid rises once its result reaches
// the output register. Throughput is one pair per cycle while out_ready
// is high. Every stage carries its own valid bit and takes a new word
// whenever it is empty or its successor moves; in_ready drops only while
// all six stages hold words and out_ready is low.
// The margin register is written with cfg_wr_en/cfg_wr_data and should
// only change while no pair is in flight.
// Synchronous reset empties the pipeline and clears the margin to zero.
`default_nettype none

module obb_aabb_overlap_2d (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] in_obb_center_x,
  input  wire logic [23:0] in_obb_center_z,
  input  wire logic [22:0] in_obb_half_length,
  input  wire logic [22:0] in_obb_half_width,
  input  wire logic [15:0] in_obb_angle,
  input  wire logic [23:0] in_box_min_x,
  input  wire logic [23:0] in_box_min_z,
  input  wire logic [23:0] in_box_max_x,
  input  wire logic [23:0] in_box_max_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_overlap,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);
  import obbov_pkg::*;

  logic [MARGIN_W-1:0] margin_r;
  item_t               item;
  logic                trig_valid, trig_ready;
  trig_t               trig_data;
  logic                proj_valid, proj_ready;
  proj_t               proj_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= '0;
    end else if (cfg_wr_en) begin
      margin_r <= cfg_wr_data;
    end
  end

  always_comb begin
    item.g.cx  = $signed(in_obb_center_x);
    item.g.cz  = $signed(in_obb_center_z);
    item.g.hl  = in_obb_half_length;
    item.g.hw  = in_obb_half_width;
    item.g.mnx = $signed(in_box_min_x);
    item.g.mnz = $signed(in_box_min_z);
    item.g.mxx = $signed(in_box_max_x);
    item.g.mxz = $signed(in_box_max_z);
    item.ang   = in_obb_angle;
  end

  obbov_trig u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (item),
    .out_valid (trig_valid),
    .out_ready (trig_ready),
    .out_data  (trig_data)
  );

  obbov_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (trig_valid),
    .in_ready  (trig_ready),
    .in_data   (trig_data),
    .out_valid (proj_valid),
    .out_ready (proj_ready),
    .out_data  (proj_data)
  );

  obbov_sep u_sep (
    .clk         (clk),
    .rst_n       (rst_n),
    .margin      (margin_r),
    .in_valid    (proj_valid),
    .in_ready    (proj_ready),
    .in_data     (proj_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_overlap (out_overlap)
  );

  // Back-pressure reaches the input only when the output word is stuck.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the output stage could move");

  // An empty output register means every stage can take a word.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word present right after reset");

endmodule

`default_nettype wire

// ----- tb/sv/obb_overlap_checker.sv -----
module obb_overlap_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [23:0] in_obb_center_x,
  input  wire logic [23:0] in_obb_center_z,
  input  wire logic [22:0] in_obb_half_length,
  input  wire logic [22:0] in_obb_half_width,
  input  wire logic [15:0] in_obb_angle,
  input  wire logic [23:0] in_box_min_x,
  input  wire logic [23:0] in_box_min_z,
  input  wire logic [23:0] in_box_max_x,
  input  wire logic [23:0] in_box_max_z,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        out_overlap,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  output int               mismatch_count,
  output int               results_due
);
  import obbov_pkg::*;

  longint      wave [0:SINE_TABLE_DEPTH];
  logic [15:0] margin_q;
  bit          overlap_due [$];
  bit          want;

  function automatic longint wave_entry(longint i);
    longint x, x2, t, y, e;
    x  = (i <<< 30) / SINE_TABLE_DEPTH;
    x2 = (x * x) / ONE_Q30;
    t  = C9;
    t  = C7 - (x2 * t) / ONE_Q30;
    t  = C5 - (x2 * t) / ONE_Q30;
    t  = C3 - (x2 * t) / ONE_Q30;
    t  = C1 - (x2 * t) / ONE_Q30;
    y  = (x * t) / ONE_Q30;
    e  = (y + 16384) / 32768;
    if (e > 32767) begin
      e = 32767;
    end
    if (e < 0) begin
      e = 0;
    end
    return e;
  endfunction

  // Bit 14 of the angle mirrors the quarter wave, bit 15 flips the sign.
  function automatic longint sine_at(logic [15:0] a);
    longint u, mag;
    u   = a[14] ? (longint'(16384) - longint'(a[13:0])) : longint'(a[13:0]);
    mag = wave[(u * SINE_TABLE_DEPTH) >> 14];
    return a[15] ? -mag : mag;
  endfunction

  // Projections are kept exact in Q38: coordinate Q8 times two Q15 factors.
  function automatic bit overlap_of(longint cx, longint cz, longint hl, longint hw,
                                    logic [15:0] ang, longint mnx, longint mnz,
                                    longint mxx, longint mxz);
    longint      sn, cs, eps, p, df, dr, rad, bmin, bmax;
    longint      ax [4];
    longint      az [4];
    logic [15:0] ang90;
    bit          sep;
    ang90 = ang + 16'd16384;
    sn    = sine_at(ang);
    cs    = sine_at(ang90);
    eps   = longint'(margin_q) * ONE_Q30;
    ax    = '{32768, 0, cs, sn};
    az    = '{0, 32768, -sn, cs};
    sep   = 1'b0;
    for (int k = 0; k < 4; k++) begin
      p    = (cx * ax[k] + cz * az[k]) * 32768;
      df   = cs * ax[k] - sn * az[k];
      dr   = sn * ax[k] + cs * az[k];
      rad  = (df < 0 ? -df : df) * hl + (dr < 0 ? -dr : dr) * hw;
      bmin = ((ax[k] * mnx < ax[k] * mxx ? ax[k] * mnx : ax[k] * mxx) +
              (az[k] * mnz < az[k] * mxz ? az[k] * mnz : az[k] * mxz)) * 32768;
      bmax = ((ax[k] * mnx > ax[k] * mxx ? ax[k] * mnx : ax[k] * mxx) +
              (az[k] * mnz > az[k] * mxz ? az[k] * mnz : az[k] * mxz)) * 32768;
      if ((p + rad < bmin - eps) || (bmax < p - rad - eps)) begin
        sep = 1'b1;
      end
    end
    return !sep;
  endfunction

  initial begin
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      wave[i] = wave_entry(i);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      margin_q = '0;
      overlap_due.delete();
      results_due <= 0;
    end else begin
      if (cfg_wr_en) begin
        margin_q = cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        if (overlap_due.size() == 0) begin
          $error("overlap: no result expected, actual %0d", out_overlap);
          mismatch_count++;
        end else begin
          want = overlap_due.pop_front();
          if (out_overlap !== want) begin
            $error("overlap mismatch: expected %0d, actual %0d", want, out_overlap);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        overlap_due.push_back(overlap_of(longint'($signed(in_obb_center_x)),
                                         longint'($signed(in_obb_center_z)),
                                         longint'(in_obb_half_length),
                                         longint'(in_obb_half_width),
                                         in_obb_angle,
                                         longint'($signed(in_box_min_x)),
                                         longint'($signed(in_box_min_z)),
                                         longint'($signed(in_box_max_x)),
                                         longint'($signed(in_box_max_z))));
      end
      results_due <= overlap_due.size();
    end
  end

endmodule

// ----- tb/sv/tb_obb_aabb_overlap_2d.sv -----
module tb_obb_aabb_overlap_2d;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cz;
    logic        [22:0] hl;
    logic        [22:0] hw;
    logic        [15:0] ang;
    logic signed [23:0] mnx;
    logic signed [23:0] mnz;
    logic signed [23:0] mxx;
    logic signed [23:0] mxz;
  } pair_t;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_ready;
  logic [23:0] in_obb_center_x    = '0;
  logic [23:0] in_obb_center_z    = '0;
  logic [22:0] in_obb_half_length = '0;
  logic [22:0] in_obb_half_width  = '0;
  logic [15:0] in_obb_angle       = '0;
  logic [23:0] in_box_min_x       = '0;
  logic [23:0] in_box_min_z       = '0;
  logic [23:0] in_box_max_x       = '0;
  logic [23:0] in_box_max_z       = '0;
  logic        out_valid;
  logic        out_ready          = 1'b0;
  logic        out_overlap;
  logic        cfg_wr_en          = 1'b0;
  logic [15:0] cfg_wr_data        = '0;

  int          mismatch_count;
  int          results_due;
  int          cycle_count        = 0;
  int          tx_idle_pct        = 0;
  int          rx_stall_pct       = 0;
  bit          rx_hold_req        = 1'b0;
  logic [15:0] margin_now         = '0;

  obb_aabb_overlap_2d uut (.*);

  obb_overlap_checker chk (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [23:0] sat24(longint v);
    if (v > 8388607) begin
      return 24'sd8388607;
    end
    if (v < -8388608) begin
      return -24'sd8388608;
    end
    return 24'(v);
  endfunction

  function automatic longint jitter(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  function automatic pair_t mk_pair(longint cx, longint cz, longint hl, longint hw,
                                    longint ang, longint mnx, longint mnz,
                                    longint mxx, longint mxz);
    pair_t p;
    p.cx  = 24'(cx);
    p.cz  = 24'(cz);
    p.hl  = 23'(hl);
    p.hw  = 23'(hw);
    p.ang = 16'(ang);
    p.mnx = 24'(mnx);
    p.mnz = 24'(mnz);
    p.mxx = 24'(mxx);
    p.mxz = 24'(mxz);
    return p;
  endfunction

  function automatic pair_t rand_pair();
    pair_t  p;
    int     mode, sc;
    bit     onz;
    longint span, cx, cz, near, ctr, gap, lo, hi, bx, bz, wx, wz;
    mode = $urandom_range(0, 99);
    if (mode < 20) begin
      p.cx  = 24'($urandom);
      p.cz  = 24'($urandom);
      p.hl  = 23'($urandom);
      p.hw  = 23'($urandom);
      p.ang = 16'($urandom);
      p.mnx = 24'($urandom);
      p.mnz = 24'($urandom);
      p.mxx = 24'($urandom);
      p.mxz = 24'($urandom);
      return p;
    end
    sc   = $urandom_range(3, 21);
    span = longint'(1) << sc;
    cx   = jitter(longint'(1) << 22);
    cz   = jitter(longint'(1) << 22);
    p.cx = sat24(cx);
    p.cz = sat24(cz);
    p.hl = 23'($urandom_range(0, 32'(span)));
    p.hw = 23'($urandom_range(0, 32'(span)));
    if (mode < 45) begin
      // Quarter-turn heading with one box face placed right at an oriented
      // box face, offset by a few units or by the margin.
      p.ang = 16'($urandom_range(0, 3)) << 14;
      onz   = 1'($urandom_range(0, 1));
      near  = (onz ^ p.ang[14]) ? longint'(p.hw) : longint'(p.hl);
      ctr   = onz ? cz : cx;
      gap   = ($urandom_range(0, 1) ? longint'(margin_now) : 0) + jitter(2);
      if ($urandom_range(0, 1)) begin
        lo = ctr + near + gap;
        hi = lo + longint'($urandom_range(0, 32'(span)));
      end else begin
        hi = ctr - near - gap;
        lo = hi - longint'($urandom_range(0, 32'(span)));
      end
      if (onz) begin
        p.mnz = sat24(lo);
        p.mxz = sat24(hi);
        p.mnx = sat24(cx + jitter(span));
        p.mxx = sat24(cx + jitter(span));
      end else begin
        p.mnx = sat24(lo);
        p.mxx = sat24(hi);
        p.mnz = sat24(cz + jitter(span));
        p.mxz = sat24(cz + jitter(span));
      end
    end else begin
      p.ang = 16'($urandom);
      bx    = cx + jitter(2 * span);
      bz    = cz + jitter(2 * span);
      wx    = longint'($urandom_range(0, 32'(span)));
      wz    = longint'($urandom_range(0, 32'(span)));
      p.mnx = sat24(bx - wx);
      p.mxx = sat24(bx + wx);
      p.mnz = sat24(bz - wz);
      p.mxz = sat24(bz + wz);
      if ($urandom_range(0, 7) == 0) begin
        p.mnx = sat24(bx + wx);
        p.mxx = sat24(bx - wx);
      end
      if ($urandom_range(0, 7) == 0) begin
        p.mnz = sat24(bz + wz);
        p.mxz = sat24(bz - wz);
      end
    end
    return p;
  endfunction

  // Valid stays high from one word to the next unless an idle cycle is drawn.
  task automatic send_pair(input pair_t p);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_obb_center_x    <= p.cx;
    in_obb_center_z    <= p.cz;
    in_obb_half_length <= p.hl;
    in_obb_half_width  <= p.hw;
    in_obb_angle       <= p.ang;
    in_box_min_x       <= p.mnx;
    in_box_min_z       <= p.mnz;
    in_box_max_x       <= p.mxx;
    in_box_max_z       <= p.mxz;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // The count of outstanding words is registered, so it reflects an edge only in the next cycle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_margin(input logic [15:0] m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    margin_now  = m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int items, input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (items) send_pair(rand_pair());
  endtask

  initial begin : rx_side
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words with the margin at its reset value.
    send_pair(mk_pair(0, 0, 256, 256, 0, -256, -256, 256, 256));
    send_pair(mk_pair(0, 0, 256, 128, 0, 256, -100, 1000, 100));
    send_pair(mk_pair(0, 0, 256, 128, 0, 257, -100, 1000, 100));
    send_pair(mk_pair(0, 0, 256, 128, 0, 1000, 100, 256, -100));
    send_pair(mk_pair(0, 0, 256, 128, 0, -50, -500, 50, -128));
    send_pair(mk_pair(100, 100, 0, 0, 5000, 0, 0, 200, 200));
    send_pair(mk_pair(300, 100, 0, 0, 5000, 0, 0, 200, 200));
    send_pair(mk_pair(0, 0, 1000, 1000, 8192, 1100, -50, 1200, 50));
    send_pair(mk_pair(0, 0, 1000, 1000, 8192, 1300, 300, 1400, 400));
    send_pair(mk_pair(-8388608, -8388608, 8388607, 8388607, 0,
                      -8388608, -8388608, 8388607, 8388607));
    send_pair(mk_pair(8388607, 8388607, 8388607, 8388607, 65535,
                      8388607, 8388607, -8388608, -8388608));
    send_pair(mk_pair(-8388608, 8388607, 0, 0, 16384,
                      8388607, -8388608, 8388607, -8388608));
    send_pair(mk_pair(0, 0, 2000, 500, 16383, 1900, -10, 2100, 10));
    send_pair(mk_pair(0, 0, 2000, 500, 16384, 1900, -10, 2100, 10));
    send_pair(mk_pair(0, 0, 2000, 500, 32767, 1900, -10, 2100, 10));
    send_pair(mk_pair(0, 0, 2000, 500, 32768, 1900, -10, 2100, 10));
    send_pair(mk_pair(0, 0, 2000, 500, 49152, 1900, -10, 2100, 10));
    send_pair(mk_pair(0, 0, 2000, 500, 65535, 1900, -10, 2100, 10));
    settle();
    set_margin(16'd1);
    send_pair(mk_pair(0, 0, 256, 128, 0, 257, -100, 1000, 100));
    settle();
    set_margin(16'hFFFF);
    send_pair(mk_pair(0, 0, 0, 0, 0, 65535, -10, 70000, 10));
    send_pair(mk_pair(0, 0, 0, 0, 0, 65536, -10, 70000, 10));
    settle();

    // The receiver holds off long enough for the pipeline to fill and stall
    // the input; afterwards the sender waits for every word to drain.
    set_margin(16'd0);
    rx_hold_req = 1'b1;
    run_phase(60, 0, 0);
    settle();
    run_phase(90, 0, 0);
    settle();
    set_margin(16'hFFFF);
    run_phase(200, 45, 0);
    settle();
    set_margin(16'($urandom));
    run_phase(200, 0, 45);
    settle();
    set_margin(16'd256);
    run_phase(200, 35, 35);
    settle();
    set_margin(16'($urandom_range(0, 8)));
    run_phase(100, 0, 0);
    settle();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
